### design/encoder_pid_speed_controller_macros.svh
// assertion macros for the encoder pid speed controller
`ifndef ENCODER_PID_SPEED_CONTROLLER_MACROS_SVH
`define ENCODER_PID_SPEED_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define EPSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define EPSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EPSC_ASSERT_SAME(label, ante, cons, msg)
`define EPSC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### design/epsc_pkg.sv
// shared types and constants of the encoder pid speed controller
package epsc_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int RAW_W       = 10;
    localparam int TARGET_W    = 8;
    localparam int TARGET10_W  = 12;
    localparam int SPEED_W     = COUNT_BITS + 3;
    localparam int SPEED_OUT_W = 19;
    localparam int SPEED_EXT_W = (SPEED_W > 20) ? SPEED_W : 20;
    localparam int DIFF_W      = SPEED_EXT_W + 1;
    localparam int ERR_W       = 20;
    localparam int DERIV_W     = ERR_W + 1;
    localparam int INTEG_W     = 32;
    localparam int DUTY_W      = 8;
    localparam int PROD_P_W    = RAW_W + 1 + ERR_W;
    localparam int PROD_I_W    = RAW_W + 1 + INTEG_W;
    localparam int PROD_D_W    = RAW_W + 1 + DERIV_W;
    localparam int SUM_W       = 46;
    localparam int QUOT_IN_W   = 25;
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 42;
    localparam int QPROD_W     = QUOT_IN_W + RECIP_W;

    // ceil(2^42 / 102300), exact for dividends below 2^25
    localparam logic [RECIP_W-1:0] RECIP = 26'd42991658;
    localparam logic signed [SUM_W-1:0] DUTY_LIMIT = SUM_W'(256 * 102300);
    localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

    localparam logic signed [SUM_W-1:0] P_SCALE = SUM_W'(50);
    localparam logic signed [SUM_W-1:0] I_SCALE = SUM_W'(2);
    localparam logic signed [SUM_W-1:0] D_SCALE = SUM_W'(200);

    typedef enum logic {
        OP_PULSE = 1'b0,
        OP_TICK  = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t          opcode;
        logic [RAW_W-1:0] target_raw;
        logic [RAW_W-1:0] prop_gain_raw;
        logic [RAW_W-1:0] integ_gain_raw;
        logic [RAW_W-1:0] deriv_gain_raw;
        logic             run_enable;
    } item_beat_t;

    typedef struct packed {
        logic                      run_enable;
        logic [RAW_W-1:0]          kp;
        logic [RAW_W-1:0]          ki;
        logic [RAW_W-1:0]          kd;
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERIV_W-1:0] deriv;
        logic [SPEED_OUT_W-1:0]    shaft_speed_tenths;
    } err_beat_t;

    typedef struct packed {
        logic                    run_enable;
        logic signed [SUM_W-1:0] sum;
        logic [SPEED_OUT_W-1:0]  shaft_speed_tenths;
    } sum_beat_t;

    typedef struct packed {
        logic [DUTY_W-1:0]      duty;
        logic                   drive_on;
        logic [SPEED_OUT_W-1:0] shaft_speed_tenths;
    } result_beat_t;

endpackage

### design/epsc_item_if.sv
// input channel: encoder pulse and control tick beats
interface epsc_item_if;
    import epsc_pkg::*;

    logic             valid;
    logic             ready;
    logic             opcode;
    logic [RAW_W-1:0] target_raw;
    logic [RAW_W-1:0] prop_gain_raw;
    logic [RAW_W-1:0] integ_gain_raw;
    logic [RAW_W-1:0] deriv_gain_raw;
    logic             run_enable;

    modport source (
        output valid, opcode, target_raw, prop_gain_raw, integ_gain_raw,
               deriv_gain_raw, run_enable,
        input  ready
    );

    modport sink (
        input  valid, opcode, target_raw, prop_gain_raw, integ_gain_raw,
               deriv_gain_raw, run_enable,
        output ready
    );
endinterface

### design/epsc_result_if.sv
// output channel: motor drive result beats
interface epsc_result_if;
    import epsc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [DUTY_W-1:0]      duty;
    logic                   drive_on;
    logic [SPEED_OUT_W-1:0] shaft_speed_tenths;

    modport source (
        output valid, duty, drive_on, shaft_speed_tenths,
        input  ready
    );

    modport sink (
        input  valid, duty, drive_on, shaft_speed_tenths,
        output ready
    );
endinterface

### design/epsc_front.sv
// input stage, pulse counter and error / integral / derivative update
`include "encoder_pid_speed_controller_macros.svh"

module epsc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  epsc_pkg::item_beat_t item_beat,
    output logic                 err_valid,
    input  logic                 err_ready,
    output epsc_pkg::err_beat_t  err_beat
);
    import epsc_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic signed [DIFF_W-1:0] ERR_HI = DIFF_W'(2 ** (ERR_W - 1) - 1);
    localparam logic signed [DIFF_W-1:0] ERR_LO = -ERR_HI - DIFF_W'(1);
    localparam logic signed [INTEG_W-1:0] INTEG_HI = {1'b0, {(INTEG_W - 1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_LO = {1'b1, {(INTEG_W - 1){1'b0}}};
    localparam logic [SPEED_EXT_W-1:0] SPEED_CAP = SPEED_EXT_W'(2 ** SPEED_OUT_W - 1);

    // floor(raw * 200 / 1023) as ((raw * 200 + 1) * 1025) >> 20
    function automatic logic [TARGET_W-1:0] target_rpm(input logic [RAW_W-1:0] raw);
        logic [17:0] scaled;
        logic [28:0] prod;
        scaled = 18'({raw, 7'b0}) + 18'({raw, 6'b0}) + 18'({raw, 3'b0}) + 18'd1;
        prod   = 29'({scaled, 10'b0}) + 29'(scaled);
        return prod[20 +: TARGET_W];
    endfunction

    item_beat_t                s1_reg;
    logic                      s1_valid_reg, s1_valid_next;
    logic [COUNT_BITS-1:0]     count_reg, count_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [ERR_W-1:0]   prev_err_reg, prev_err_next;
    logic                      err_valid_reg, err_valid_next;
    err_beat_t                 err_beat_reg, err_beat_next;

    logic                      s1_leave;
    logic                      item_fire;
    logic                      tick_fire;
    logic [TARGET_W-1:0]       target;
    logic [TARGET10_W-1:0]     target10;
    logic [SPEED_W-1:0]        speed;
    logic [SPEED_EXT_W-1:0]    speed_ext;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  diff_sat;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [DERIV_W-1:0] deriv;
    logic [SPEED_OUT_W-1:0]    speed_out;

    // pulse beats retire here, ticks move on when the next stage has room
    assign s1_leave   = s1_valid_reg && (s1_reg.opcode == OP_PULSE || !err_valid_reg || err_ready);
    assign item_ready = !s1_valid_reg || s1_leave;
    assign item_fire  = item_valid && item_ready;
    assign tick_fire  = s1_leave && s1_reg.opcode == OP_TICK;

    assign target    = target_rpm(s1_reg.target_raw);
    assign target10  = TARGET10_W'({target, 3'b0}) + TARGET10_W'({target, 1'b0});
    assign speed     = SPEED_W'({count_reg, 2'b0}) + SPEED_W'({count_reg, 1'b0});
    assign speed_ext = SPEED_EXT_W'(speed);
    assign diff      = $signed(DIFF_W'(target10)) - $signed({1'b0, speed_ext});
    assign speed_out = (speed_ext > SPEED_CAP) ? SPEED_OUT_W'(SPEED_CAP)
                                               : speed_ext[SPEED_OUT_W-1:0];

    always_comb
    begin
        if (diff > ERR_HI)
        begin
            diff_sat = ERR_HI;
        end
        else if (diff < ERR_LO)
        begin
            diff_sat = ERR_LO;
        end
        else
        begin
            diff_sat = diff;
        end
    end

    assign err       = diff_sat[ERR_W-1:0];
    assign integ_sum = (INTEG_W + 1)'(integ_reg) + (INTEG_W + 1)'(err);
    assign deriv     = DERIV_W'(err) - DERIV_W'(prev_err_reg);

    always_comb
    begin
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
        begin
            integ_sat = integ_sum[INTEG_W] ? INTEG_LO : INTEG_HI;
        end
        else
        begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        integ_next    = integ_reg;
        prev_err_next = prev_err_reg;
        if (s1_leave)
        begin
            if (s1_reg.opcode == OP_PULSE)
            begin
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else if (s1_reg.run_enable)
            begin
                count_next    = '0;
                integ_next    = integ_sat;
                prev_err_next = err;
            end
        end
    end

    assign s1_valid_next  = item_fire ? 1'b1 : (s1_leave ? 1'b0 : s1_valid_reg);
    assign err_valid_next = tick_fire ? 1'b1 : (err_ready ? 1'b0 : err_valid_reg);

    always_comb
    begin
        err_beat_next.run_enable         = s1_reg.run_enable;
        err_beat_next.kp                 = s1_reg.prop_gain_raw;
        err_beat_next.ki                 = s1_reg.integ_gain_raw;
        err_beat_next.kd                 = s1_reg.deriv_gain_raw;
        err_beat_next.err                = err;
        err_beat_next.integ              = integ_sat;
        err_beat_next.deriv              = deriv;
        err_beat_next.shaft_speed_tenths = speed_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            err_valid_reg <= 1'b0;
            count_reg     <= '0;
            integ_reg     <= '0;
            prev_err_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            err_valid_reg <= err_valid_next;
            count_reg     <= count_next;
            integ_reg     <= integ_next;
            prev_err_reg  <= prev_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_reg <= item_beat;
        end
        if (tick_fire)
        begin
            err_beat_reg <= err_beat_next;
        end
    end

    assign err_valid = err_valid_reg;
    assign err_beat  = err_beat_reg;

    `EPSC_ASSERT_NEXT(a_count_saturates, s1_leave && s1_reg.opcode == OP_PULSE && count_reg == COUNT_MAX, count_reg == COUNT_MAX, "pulse count wrapped past its maximum")
    `EPSC_ASSERT_NEXT(a_count_cleared, tick_fire && s1_reg.run_enable, count_reg == '0, "enabled tick did not clear the pulse count")
    `EPSC_ASSERT_NEXT(a_idle_tick_keeps, tick_fire && !s1_reg.run_enable, $stable(integ_reg) && $stable(prev_err_reg), "disabled tick changed controller state")

endmodule

### design/epsc_mac.sv
// gain products and weighted control sum
module epsc_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                err_valid,
    output logic                err_ready,
    input  epsc_pkg::err_beat_t err_beat,
    output logic                sum_valid,
    input  logic                sum_ready,
    output epsc_pkg::sum_beat_t sum_beat
);
    import epsc_pkg::*;

    typedef struct packed {
        logic                       run_enable;
        logic signed [PROD_P_W-1:0] p_prod;
        logic signed [PROD_I_W-1:0] i_prod;
        logic signed [PROD_D_W-1:0] d_prod;
        logic [SPEED_OUT_W-1:0]     shaft_speed_tenths;
    } prod_beat_t;

    prod_beat_t prod_reg, prod_next;
    logic       prod_valid_reg, prod_valid_next;
    sum_beat_t  sum_reg, sum_next;
    logic       sum_valid_reg, sum_valid_next;
    logic       err_fire;
    logic       prod_leave;

    assign prod_leave = prod_valid_reg && (!sum_valid_reg || sum_ready);
    assign err_ready  = !prod_valid_reg || prod_leave;
    assign err_fire   = err_valid && err_ready;

    always_comb
    begin
        prod_next.run_enable         = err_beat.run_enable;
        prod_next.p_prod             = $signed({1'b0, err_beat.kp}) * err_beat.err;
        prod_next.i_prod             = $signed({1'b0, err_beat.ki}) * err_beat.integ;
        prod_next.d_prod             = $signed({1'b0, err_beat.kd}) * err_beat.deriv;
        prod_next.shaft_speed_tenths = err_beat.shaft_speed_tenths;
    end

    always_comb
    begin
        sum_next.run_enable         = prod_reg.run_enable;
        sum_next.sum                = SUM_W'(prod_reg.p_prod) * P_SCALE
                                    + SUM_W'(prod_reg.i_prod) * I_SCALE
                                    + SUM_W'(prod_reg.d_prod) * D_SCALE;
        sum_next.shaft_speed_tenths = prod_reg.shaft_speed_tenths;
    end

    assign prod_valid_next = err_fire ? 1'b1 : (prod_leave ? 1'b0 : prod_valid_reg);
    assign sum_valid_next  = prod_leave ? 1'b1 : (sum_ready ? 1'b0 : sum_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            sum_valid_reg  <= sum_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (err_fire)
        begin
            prod_reg <= prod_next;
        end
        if (prod_leave)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum_beat  = sum_reg;

endmodule

### design/epsc_duty.sv
// duty scaling, clamp and result register
`include "encoder_pid_speed_controller_macros.svh"

module epsc_duty (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sum_valid,
    output logic                   sum_ready,
    input  epsc_pkg::sum_beat_t    sum_beat,
    output logic                   result_valid,
    input  logic                   result_ready,
    output epsc_pkg::result_beat_t result_beat
);
    import epsc_pkg::*;

    result_beat_t       result_reg, result_next;
    logic               result_valid_reg, result_valid_next;
    logic               sum_fire;
    logic               sum_neg;
    logic               sum_big;
    logic [QPROD_W-1:0] quot_prod;
    logic [DUTY_W-1:0]  quot;

    assign sum_ready = !result_valid_reg || result_ready;
    assign sum_fire  = sum_valid && sum_ready;

    // divide by 102300 through the reciprocal, only below the clamp limit
    assign sum_neg   = sum_beat.sum[SUM_W-1];
    assign sum_big   = sum_beat.sum >= DUTY_LIMIT;
    assign quot_prod = QPROD_W'(sum_beat.sum[QUOT_IN_W-1:0]) * QPROD_W'(RECIP);
    assign quot      = quot_prod[RECIP_SHIFT +: DUTY_W];

    always_comb
    begin
        result_next.drive_on = sum_beat.run_enable;
        if (!sum_beat.run_enable)
        begin
            result_next.duty               = '0;
            result_next.shaft_speed_tenths = '0;
        end
        else
        begin
            result_next.shaft_speed_tenths = sum_beat.shaft_speed_tenths;
            if (sum_neg)
            begin
                result_next.duty = '0;
            end
            else if (sum_big)
            begin
                result_next.duty = DUTY_MAX;
            end
            else
            begin
                result_next.duty = quot;
            end
        end
    end

    assign result_valid_next = sum_fire ? 1'b1 : (result_ready ? 1'b0 : result_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_beat  = result_reg;

    `EPSC_ASSERT_SAME(a_stopped_fields, result_valid_reg && !result_reg.drive_on, result_reg.duty == '0 && result_reg.shaft_speed_tenths == '0, "stopped result carries nonzero fields")
    `EPSC_ASSERT_NEXT(a_negative_sum, sum_fire && sum_beat.run_enable && sum_neg, result_reg.duty == '0 && result_reg.drive_on, "negative control sum gave nonzero duty")

endmodule

### design/encoder_pid_speed_controller.sv
// top level of the encoder pid speed controller
//
// channel   side  beat contents
// item      in    opcode, target_raw, prop/integ/deriv_gain_raw, run_enable
// result    out   duty, drive_on, shaft_speed_tenths
//
// one beat accepted per cycle while the input stage can take it; a pulse beat
// retires in the input stage; a tick beat reaches the result through the
// input, error/integral, product, sum and output registers
// reset clears all valids, the pulse count, the integral and the last error
// a stalled result blocks input only once the tick stages behind it are full;
// pulse beats keep being taken while the input stage can retire them
module encoder_pid_speed_controller (
    input  logic          clk,
    input  logic          rst_n,
    epsc_item_if.sink     item,
    epsc_result_if.source result
);
    import epsc_pkg::*;

    item_beat_t   item_beat;
    err_beat_t    err_beat;
    sum_beat_t    sum_beat;
    result_beat_t result_beat;
    logic         err_valid;
    logic         err_ready;
    logic         sum_valid;
    logic         sum_ready;

    assign item_beat.opcode         = opcode_t'(item.opcode);
    assign item_beat.target_raw     = item.target_raw;
    assign item_beat.prop_gain_raw  = item.prop_gain_raw;
    assign item_beat.integ_gain_raw = item.integ_gain_raw;
    assign item_beat.deriv_gain_raw = item.deriv_gain_raw;
    assign item_beat.run_enable     = item.run_enable;

    epsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .item_beat  (item_beat),
        .err_valid  (err_valid),
        .err_ready  (err_ready),
        .err_beat   (err_beat)
    );

    epsc_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .err_valid (err_valid),
        .err_ready (err_ready),
        .err_beat  (err_beat),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum_beat  (sum_beat)
    );

    epsc_duty u_duty (
        .clk          (clk),
        .rst_n        (rst_n),
        .sum_valid    (sum_valid),
        .sum_ready    (sum_ready),
        .sum_beat     (sum_beat),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .result_beat  (result_beat)
    );

    assign result.duty               = result_beat.duty;
    assign result.drive_on           = result_beat.drive_on;
    assign result.shaft_speed_tenths = result_beat.shaft_speed_tenths;

endmodule

### verif/epsc_drive_check.sv
// checker that predicts motor drive results from item beats and compares them
module epsc_drive_check (
    input  logic   clk,
    input  logic   rst_n,
    epsc_item_if   item,
    epsc_result_if result,
    output int     errors,
    output int     pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import epsc_pkg::*;

    localparam longint ERR_LO   = -(longint'(1) << (ERR_W - 1));
    localparam longint ERR_HI   = (longint'(1) << (ERR_W - 1)) - 1;
    localparam longint INTEG_LO = -(longint'(1) << (INTEG_W - 1));
    localparam longint INTEG_HI = (longint'(1) << (INTEG_W - 1)) - 1;
    localparam longint SPEED_HI = (longint'(1) << SPEED_OUT_W) - 1;
    localparam longint DUTY_DIV = 102300;

    logic [COUNT_BITS-1:0]     edge_count;
    logic signed [INTEG_W-1:0] integ_acc;
    logic signed [ERR_W-1:0]   last_err;
    result_beat_t              drive_q[$];
    int                        mismatch_count;

    function automatic longint clamp_range(input longint v, input longint lo,
                                           input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // one control period: speed from the edge count, then pid and duty
    function automatic result_beat_t pid_tick(input item_beat_t b);
        result_beat_t r;
        longint       speed;
        longint       target;
        longint       err;
        longint       integ;
        longint       deriv;
        longint       sum;
        longint       duty;
        longint       speed_out;
        r = '0;
        if (!b.run_enable)
            return r;
        speed = longint'(edge_count) * 6;
        edge_count = '0;
        target = longint'(b.target_raw) * 200 / 1023;
        err = clamp_range(target * 10 - speed, ERR_LO, ERR_HI);
        integ = clamp_range(longint'(integ_acc) + err, INTEG_LO, INTEG_HI);
        integ_acc = integ[INTEG_W-1:0];
        deriv = err - longint'(last_err);
        last_err = err[ERR_W-1:0];
        sum = 50 * longint'(b.prop_gain_raw) * err
            + 2 * longint'(b.integ_gain_raw) * integ
            + 200 * longint'(b.deriv_gain_raw) * deriv;
        if (sum < 0)
            duty = 0;
        else
            duty = clamp_range(sum / DUTY_DIV, 0, 255);
        speed_out = clamp_range(speed, 0, SPEED_HI);
        r.duty = duty[DUTY_W-1:0];
        r.drive_on = 1'b1;
        r.shaft_speed_tenths = speed_out[SPEED_OUT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        item_beat_t   beat;
        result_beat_t want;
        if (!rst_n)
        begin
            edge_count = '0;
            integ_acc = '0;
            last_err = '0;
            drive_q.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                beat.opcode = opcode_t'(item.opcode);
                beat.target_raw = item.target_raw;
                beat.prop_gain_raw = item.prop_gain_raw;
                beat.integ_gain_raw = item.integ_gain_raw;
                beat.deriv_gain_raw = item.deriv_gain_raw;
                beat.run_enable = item.run_enable;
                if (beat.opcode == OP_PULSE)
                begin
                    if (edge_count != '1)
                        edge_count = edge_count + 1'b1;
                end
                else
                    drive_q.push_back(pid_tick(beat));
            end
            if (result.valid && result.ready)
            begin
                if (drive_q.size() == 0)
                begin
                    $error("unexpected result beat: duty %0d drive_on %0d speed %0d",
                           result.duty, result.drive_on, result.shaft_speed_tenths);
                    mismatch_count++;
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (result.duty !== want.duty)
                    begin
                        $error("duty: expected %0d, actual %0d", want.duty, result.duty);
                        mismatch_count++;
                    end
                    if (result.drive_on !== want.drive_on)
                    begin
                        $error("drive_on: expected %0d, actual %0d",
                               want.drive_on, result.drive_on);
                        mismatch_count++;
                    end
                    if (result.shaft_speed_tenths !== want.shaft_speed_tenths)
                    begin
                        $error("shaft_speed_tenths: expected %0d, actual %0d",
                               want.shaft_speed_tenths, result.shaft_speed_tenths);
                        mismatch_count++;
                    end
                end
            end
        end
        errors = mismatch_count;
        pending = drive_q.size();
    end

endmodule

### verif/testbench.sv
// top of the speed controller testbench: stimulus, receiver, watchdog and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import epsc_pkg::*;

    localparam int RANDOM_BEATS   = 480;
    localparam int STEADY_PULSES  = 80;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 10;

    logic clk;
    logic rst_n;
    logic idle_on;
    logic hold_req;
    int   error_count;
    int   pending_count;
    int   beat_total;
    int   quiet_cycles;
    int   burst;

    epsc_item_if   item_ch ();
    epsc_result_if result_ch ();

    encoder_pid_speed_controller dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    epsc_drive_check drive_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .errors  (error_count),
        .pending (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [RAW_W-1:0] random_gain();
        if ($urandom_range(0, 3) == 0)
            return RAW_W'($urandom_range(0, 1023));
        return RAW_W'($urandom_range(0, 1023) >> $urandom_range(1, 9));
    endfunction

    function automatic item_beat_t random_beat(input opcode_t op);
        item_beat_t b;
        b.opcode = op;
        b.target_raw = RAW_W'($urandom_range(0, 1023));
        b.prop_gain_raw = random_gain();
        b.integ_gain_raw = random_gain();
        b.deriv_gain_raw = random_gain();
        b.run_enable = ($urandom_range(0, 4) != 0);
        return b;
    endfunction

    function automatic item_beat_t make_tick(input int traw, input int kp, input int ki,
                                             input int kd, input logic en);
        item_beat_t b;
        b.opcode = OP_TICK;
        b.target_raw = RAW_W'(traw);
        b.prop_gain_raw = RAW_W'(kp);
        b.integ_gain_raw = RAW_W'(ki);
        b.deriv_gain_raw = RAW_W'(kd);
        b.run_enable = en;
        return b;
    endfunction

    task automatic send_beat(input item_beat_t b);
        while (idle_on && $urandom_range(0, 99) < 31)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.opcode <= b.opcode;
        item_ch.target_raw <= b.target_raw;
        item_ch.prop_gain_raw <= b.prop_gain_raw;
        item_ch.integ_gain_raw <= b.integ_gain_raw;
        item_ch.deriv_gain_raw <= b.deriv_gain_raw;
        item_ch.run_enable <= b.run_enable;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        beat_total++;
    endtask

    task automatic send_pulses(input int n);
        repeat (n) send_beat(random_beat(OP_PULSE));
    endtask

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                result_ch.ready <= !(idle_on && $urandom_range(0, 99) < 31);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n <= 1'b0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        beat_total = 0;
        item_ch.valid <= 1'b0;
        item_ch.opcode <= OP_PULSE;
        item_ch.target_raw <= '0;
        item_ch.prop_gain_raw <= '0;
        item_ch.integ_gain_raw <= '0;
        item_ch.deriv_gain_raw <= '0;
        item_ch.run_enable <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_beat(make_tick(1023, 1023, 1023, 1023, 1'b0));
        send_beat(make_tick(1023, 1023, 1023, 1023, 1'b1));
        send_beat(make_tick(0, 1023, 1023, 1023, 1'b1));
        send_pulses(5);
        send_beat(make_tick(0, 1023, 0, 1023, 1'b1));
        send_pulses(4);
        send_beat(make_tick(512, 300, 300, 300, 1'b0));
        send_pulses(3);
        send_beat(make_tick(512, 300, 300, 300, 1'b1));
        send_beat(make_tick(700, 0, 0, 0, 1'b1));
        send_pulses(2);
        send_beat(make_tick(1023, 1, 0, 0, 1'b1));
        send_beat(make_tick(300, 0, 1023, 0, 1'b1));

        // steady stream of edges, no idling on either side
        idle_on = 1'b0;
        send_pulses(STEADY_PULSES);
        send_beat(make_tick(1023, 512, 1, 512, 1'b1));
        send_beat(make_tick(1023, 512, 1, 512, 1'b1));
        idle_on = 1'b1;

        // receiver holds off while ticks keep coming
        hold_req = 1'b1;
        repeat (12) send_beat(random_beat(OP_TICK));
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);

        // random bursts of edges closed by a tick
        beat_total = 0;
        while (beat_total < RANDOM_BEATS)
        begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                : $urandom_range(0, 10);
            send_pulses(burst);
            send_beat(random_beat(OP_TICK));
        end
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
